// ----- rtl/double_hash_table_engine_top_macros.svh -----
// Assertion macros for the double hash table engine.
// Used by double_hash_table_engine_top; expects clk and rst_n in scope.
`ifndef DOUBLE_HASH_TABLE_ENGINE_TOP_MACROS_SVH
`define DOUBLE_HASH_TABLE_ENGINE_TOP_MACROS_SVH

// cond holds at every edge out of reset
`define DHTE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define DHTE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define DHTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dhte_pkg.sv -----
// Shared constants and field widths for the double hash table engine.
// No dependencies.
`default_nettype none

package dhte_pkg;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 31;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  localparam logic [2:0] STEP_BASE = 3'd7;

  // key bits consumed per reduction cycle, and cycles per key
  localparam int RED_BITS   = 4;
  localparam int RED_CYCLES = 8;

endpackage

`default_nettype wire

// ----- rtl/dhte_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module dhte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/dhte_reducer.sv -----
// Digit-serial reduction of a key modulo the table size and modulo 7.
// Depends on dhte_pkg.
`default_nettype none

module dhte_reducer #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [dhte_pkg::KEY_W-1:0]     key,
  output logic                                done,
  output logic      [$clog2(TABLE_SLOTS)-1:0] rem_n,
  output logic      [2:0]                     rem_7
);

  localparam int RW = $clog2(TABLE_SLOTS);
  localparam int SHW = dhte_pkg::RED_BITS * dhte_pkg::RED_CYCLES;
  localparam int CW = $clog2(dhte_pkg::RED_CYCLES);
  localparam logic [RW:0] MOD_N = (RW+1)'(TABLE_SLOTS);
  localparam logic [3:0] MOD_7 = 4'd7;

  logic [SHW-1:0] shreg_r, shreg_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [RW-1:0]  remn_r, remn_nxt;
  logic [2:0]     rem7_r, rem7_nxt;

  logic [RW:0] tn;
  logic [3:0]  t7;
  logic [dhte_pkg::RED_BITS-1:0] digit;

  always_comb begin
    tn = {1'b0, remn_r};
    t7 = {1'b0, rem7_r};
    digit = shreg_r[SHW-1 -: dhte_pkg::RED_BITS];
    for (int i = dhte_pkg::RED_BITS - 1; i >= 0; i--) begin
      tn = {tn[RW-1:0], digit[i]};
      if (tn >= MOD_N) begin
        tn = tn - MOD_N;
      end
      t7 = {t7[2:0], digit[i]};
      if (t7 >= MOD_7) begin
        t7 = t7 - MOD_7;
      end
    end
  end

  always_comb begin
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    remn_nxt  = remn_r;
    rem7_nxt  = rem7_r;
    if (start) begin
      shreg_nxt = SHW'(key);
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
      remn_nxt  = '0;
      rem7_nxt  = '0;
    end else if (busy_r) begin
      shreg_nxt = shreg_r << dhte_pkg::RED_BITS;
      cnt_nxt   = cnt_r + 1'b1;
      remn_nxt  = tn[RW-1:0];
      rem7_nxt  = t7[2:0];
      if (cnt_r == CW'(dhte_pkg::RED_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shreg_r <= shreg_nxt;
    remn_r  <= remn_nxt;
    rem7_r  <= rem7_nxt;
  end

  assign done  = done_r;
  assign rem_n = remn_r;
  assign rem_7 = rem7_r;

endmodule

`default_nettype wire

// ----- rtl/double_hash_table_engine_top.sv -----
// Top level of the double hash table engine: control sequencer and table memory.
// Depends on dhte_pkg, dhte_ram, dhte_reducer and the assertion macro header.
//
// Open-addressing hash table with double hashing, one operation per item
// (insert, remove, search), one result per item. Each table entry lives in
// one RAM word as {valid, key}. After reset a clearing pass writes every
// entry empty, one per cycle, so in_ready stays low until the pass ends.
// A valid operation passes through S_REDUCE, S_STEP, S_CHECK and S_FINISH: the key
// is reduced modulo the table size and modulo 7, 4 bits per cycle, the step
// comes from the modulo-7 remainder, S_STEP issues the first RAM read, and
// each of P probes (1 to TABLE_SLOTS) checks one entry in S_CHECK. Items are
// handled one at a time; a finished result waits in the output register.
`default_nettype none
`include "double_hash_table_engine_top_macros.svh"

module double_hash_table_engine_top #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dhte_pkg::OP_W-1:0]      in_operation,
  input  wire logic [dhte_pkg::KEY_W-1:0]     in_key,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dhte_pkg::STAT_W-1:0]    out_status,
  output logic      [dhte_pkg::SLOT_W-1:0]    out_slot
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int MW = dhte_pkg::KEY_W + 1;
  localparam logic [SW:0] MOD_N = (SW+1)'(TABLE_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_REDUCE = 6'b000100,
    S_STEP   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [dhte_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [dhte_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [SW-1:0]               idx_r, idx_nxt;
  logic [SW-1:0]               stepn_r, stepn_nxt;
  logic [SW-1:0]               cnt_r, cnt_nxt;
  logic [dhte_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [dhte_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [dhte_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [dhte_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic                        red_start;
  logic                        red_done;
  logic [SW-1:0]               red_remn;
  logic [2:0]                  red_rem7;

  logic                        ram_we;
  logic [SW-1:0]               ram_waddr;
  logic [MW-1:0]               ram_wdata;
  logic                        ram_re;
  logic [SW-1:0]               ram_raddr;
  logic [MW-1:0]               ram_rdata;

  logic                        ent_valid;
  logic                        ent_match;
  logic                        last_probe;
  logic [SW:0]                 adv_sum;
  logic [SW-1:0]               idx_adv;
  logic [SW+dhte_pkg::SLOT_W-1:0] idx_ext;

  function automatic logic [SW-1:0] mod_small(input logic [2:0] v);
    logic [SW:0] t;
    t = '0;
    for (int i = 2; i >= 0; i--) begin
      t = {t[SW-1:0], v[i]};
      if (t >= MOD_N) begin
        t = t - MOD_N;
      end
    end
    return t[SW-1:0];
  endfunction

  dhte_reducer #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_reducer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .key   (in_key),
    .done  (red_done),
    .rem_n (red_remn),
    .rem_7 (red_rem7)
  );

  dhte_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_valid  = ram_rdata[MW-1];
  assign ent_match  = ram_rdata[dhte_pkg::KEY_W-1:0] == key_r;
  assign last_probe = cnt_r == LAST_IDX;
  assign adv_sum    = {1'b0, idx_r} + {1'b0, stepn_r};
  assign idx_adv    = (adv_sum >= MOD_N) ? SW'(adv_sum - MOD_N) : adv_sum[SW-1:0];
  assign idx_ext    = {{dhte_pkg::SLOT_W{1'b0}}, idx_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    stepn_nxt      = stepn_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    in_ready       = 1'b0;
    red_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = {1'b1, key_r};
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_operation;
          key_nxt = in_key;
          if (in_operation == dhte_pkg::OP_INSERT || in_operation == dhte_pkg::OP_REMOVE ||
              in_operation == dhte_pkg::OP_SEARCH) begin
            red_start = 1'b1;
            state_nxt = S_REDUCE;
          end else begin
            res_status_nxt = dhte_pkg::STAT_NOT_FOUND;
            res_slot_nxt   = '0;
            state_nxt      = S_FINISH;
          end
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (last_probe) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_REDUCE: begin
        if (red_done) begin
          idx_nxt   = red_remn;
          stepn_nxt = mod_small(dhte_pkg::STEP_BASE - red_rem7);
          cnt_nxt   = '0;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        ram_re    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        res_slot_nxt = '0;
        if (op_r == dhte_pkg::OP_INSERT) begin
          if (!ent_valid) begin
            ram_we         = 1'b1;
            res_status_nxt = dhte_pkg::STAT_DONE;
            res_slot_nxt   = idx_ext[dhte_pkg::SLOT_W-1:0];
            state_nxt      = S_FINISH;
          end else if (last_probe) begin
            res_status_nxt = dhte_pkg::STAT_FULL;
            state_nxt      = S_FINISH;
          end
        end else begin
          if (!ent_valid) begin
            res_status_nxt = dhte_pkg::STAT_NOT_FOUND;
            state_nxt      = S_FINISH;
          end else if (ent_match) begin
            ram_we         = op_r == dhte_pkg::OP_REMOVE;
            ram_wdata      = {1'b0, key_r};
            res_status_nxt = dhte_pkg::STAT_DONE;
            res_slot_nxt   = idx_ext[dhte_pkg::SLOT_W-1:0];
            state_nxt      = S_FINISH;
          end else if (last_probe) begin
            res_status_nxt = dhte_pkg::STAT_NOT_FOUND;
            state_nxt      = S_FINISH;
          end
        end
        if (state_nxt == S_CHECK) begin
          ram_re    = 1'b1;
          ram_raddr = idx_adv;
          idx_nxt   = idx_adv;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    stepn_r      <= stepn_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  `DHTE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  `DHTE_ASSERT_IMPLY(a_we_state, ram_we, state_r == S_CLEAR || state_r == S_CHECK, "stray table write")
  `DHTE_ASSERT_IMPLY(a_red_done, red_done, state_r == S_REDUCE, "reduction done out of sequence")
  `DHTE_ASSERT_ALWAYS(a_idx_range, idx_r <= LAST_IDX || state_r != S_CHECK, "probe index out of range")

endmodule

`default_nettype wire
